[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

[hw/rtl/biq_pkg.sv]
// ----------------------------------------------------------------------------
// biq_pkg
// Widths, codes and shared types of the biquad section.
// ----------------------------------------------------------------------------
package biq_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS     = 18;
    localparam int COEF_FRAC     = COEF_BITS - 2;
    localparam int W_BITS        = 32;
    localparam int PROD_BITS     = COEF_BITS + W_BITS;
    localparam int ACC_BITS      = PROD_BITS + 2;
    localparam int SH_BITS       = ACC_BITS - COEF_FRAC;
    localparam int CFG_ADDR_BITS = 3;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_FF0 = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_FF1 = CFG_ADDR_BITS'(1);
    localparam logic [CFG_ADDR_BITS-1:0] REG_FF2 = CFG_ADDR_BITS'(2);
    localparam logic [CFG_ADDR_BITS-1:0] REG_FB1 = CFG_ADDR_BITS'(3);
    localparam logic [CFG_ADDR_BITS-1:0] REG_FB2 = CFG_ADDR_BITS'(4);

    // 1.0 in Q2.(COEF_BITS-2)
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB1,
        ST_FB2,
        ST_WSAT,
        ST_FF0,
        ST_FF1,
        ST_FF2,
        ST_OUT
    } biq_state_t;

    typedef enum logic [2:0] {
        MUL_FB1,
        MUL_FB2,
        MUL_FF0,
        MUL_FF1,
        MUL_FF2
    } biq_mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ADD,
        ACC_SUB
    } biq_acc_op_t;

    typedef struct packed {
        logic         take_in;   // load acc with x plus rounding half
        logic         mul_en;    // capture a product
        biq_mul_sel_t mul_sel;
        biq_acc_op_t  acc_op;
        logic         acc_half;  // restart acc at rounding half
        logic         w_load;    // capture saturated w
        logic         out_load;  // capture saturated y, shift delays
    } biq_cmd_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] ff0;
        logic signed [COEF_BITS-1:0] ff1;
        logic signed [COEF_BITS-1:0] ff2;
        logic signed [COEF_BITS-1:0] fb1;
        logic signed [COEF_BITS-1:0] fb2;
    } biq_coef_t;

endpackage

[hw/rtl/biq_regs.sv]
// ----------------------------------------------------------------------------
// biq_regs
// Coefficient register file, written through the plain config port.
// ----------------------------------------------------------------------------
module biq_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [biq_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [biq_pkg::COEF_BITS-1:0]    cfg_wdata,
    output biq_pkg::biq_coef_t               coef
);
    import biq_pkg::*;

    biq_coef_t coef_reg, coef_next;

    always_comb begin
        coef_next = coef_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_FF0: coef_next.ff0 = cfg_wdata;
                REG_FF1: coef_next.ff1 = cfg_wdata;
                REG_FF2: coef_next.ff2 = cfg_wdata;
                REG_FB1: coef_next.fb1 = cfg_wdata;
                REG_FB2: coef_next.fb2 = cfg_wdata;
                default: coef_next = coef_reg;   // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.ff0 <= COEF_ONE;
            coef_reg.ff1 <= '0;
            coef_reg.ff2 <= '0;
            coef_reg.fb1 <= '0;
            coef_reg.fb2 <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

[hw/rtl/biq_ctrl.sv]
// ----------------------------------------------------------------------------
// biq_ctrl
// Sequencer for the shared multiply-accumulate, plus output valid.
// ----------------------------------------------------------------------------
module biq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output biq_pkg::biq_cmd_t cmd
);
    import biq_pkg::*;

    biq_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_FB1;
            ST_FB1:  state_next = ST_FB2;
            ST_FB2:  state_next = ST_WSAT;
            ST_WSAT: state_next = ST_FF0;
            ST_FF0:  state_next = ST_FF1;
            ST_FF1:  state_next = ST_FF2;
            ST_FF2:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MUL_FF0;
        cmd.acc_op  = ACC_HOLD;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // no request is taken while reset is held
                s_ready     = aresetn;
                cmd.take_in = s_valid;
            end
            ST_FB1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FB1;
            end
            ST_FB2: begin
                cmd.acc_op  = ACC_SUB;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FB2;
            end
            ST_WSAT: begin
                cmd.acc_op   = ACC_SUB;
                cmd.w_load   = 1'b1;
                cmd.acc_half = 1'b1;
            end
            ST_FF0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FF0;
            end
            ST_FF1: begin
                cmd.acc_op  = ACC_ADD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FF1;
            end
            ST_FF2: begin
                cmd.acc_op  = ACC_ADD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FF2;
            end
            ST_OUT: begin
                // hold the sum until the output register frees up
                if (out_free) begin
                    cmd.acc_op   = ACC_ADD;
                    cmd.out_load = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[hw/rtl/biq_dp.sv]
// ----------------------------------------------------------------------------
// biq_dp
// Shared multiplier, accumulator, delay line and output register.
// ----------------------------------------------------------------------------
module biq_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  biq_pkg::biq_cmd_t                    cmd,
    input  biq_pkg::biq_coef_t                   coef,
    input  logic signed [biq_pkg::SAMPLE_BITS-1:0] s_sample_in,
    input  logic                                 s_block_end,
    output logic signed [biq_pkg::SAMPLE_BITS-1:0] m_sample_out,
    output logic                                 m_block_end_out
);
    import biq_pkg::*;

    localparam int ACC_EXT = ACC_BITS - PROD_BITS;
    localparam int X_EXT   = ACC_BITS - SAMPLE_BITS - COEF_FRAC;
    localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) << (COEF_FRAC - 1);
    localparam logic signed [W_BITS-1:0] W_MAX = {1'b0, {(W_BITS-1){1'b1}}};
    localparam logic signed [W_BITS-1:0] W_MIN = {1'b1, {(W_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [ACC_BITS-1:0]    acc_reg, acc_next, acc_sum, prod_ext, x_term;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [COEF_BITS-1:0]   coef_mux;
    logic signed [W_BITS-1:0]      state_mux;
    logic signed [W_BITS-1:0]      w_reg, d1_reg, d2_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic                          end_in_reg, end_out_reg;
    logic signed [SH_BITS-1:0]     acc_sh;
    logic signed [W_BITS-1:0]      w_sat;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    // operand select
    always_comb begin
        case (cmd.mul_sel)
            MUL_FB1: begin coef_mux = coef.fb1; state_mux = d1_reg; end
            MUL_FB2: begin coef_mux = coef.fb2; state_mux = d2_reg; end
            MUL_FF0: begin coef_mux = coef.ff0; state_mux = w_reg;  end
            MUL_FF1: begin coef_mux = coef.ff1; state_mux = d1_reg; end
            MUL_FF2: begin coef_mux = coef.ff2; state_mux = d2_reg; end
            default: begin coef_mux = coef.ff0; state_mux = w_reg;  end
        endcase
    end

    assign prod_ext = {{ACC_EXT{prod_reg[PROD_BITS-1]}}, prod_reg};
    assign x_term   = {{X_EXT{s_sample_in[SAMPLE_BITS-1]}}, s_sample_in,
                       {COEF_FRAC{1'b0}}};

    always_comb begin
        case (cmd.acc_op)
            ACC_ADD: acc_sum = acc_reg + prod_ext;
            ACC_SUB: acc_sum = acc_reg - prod_ext;
            default: acc_sum = acc_reg;
        endcase
    end

    always_comb begin
        if (cmd.take_in) begin
            acc_next = x_term + ACC_HALF;
        end else if (cmd.acc_half) begin
            acc_next = ACC_HALF;
        end else begin
            acc_next = acc_sum;
        end
    end

    // floor to sample scale: half was pre-added, so this is round half up
    assign acc_sh = acc_sum[ACC_BITS-1:COEF_FRAC];

    always_comb begin
        if (acc_sh[SH_BITS-1:W_BITS-1] == {(SH_BITS-W_BITS+1){acc_sh[SH_BITS-1]}}) begin
            w_sat = acc_sh[W_BITS-1:0];
        end else begin
            w_sat = acc_sh[SH_BITS-1] ? W_MIN : W_MAX;
        end
    end

    always_comb begin
        if (acc_sh[SH_BITS-1:SAMPLE_BITS-1] ==
            {(SH_BITS-SAMPLE_BITS+1){acc_sh[SH_BITS-1]}}) begin
            y_sat = acc_sh[SAMPLE_BITS-1:0];
        end else begin
            y_sat = acc_sh[SH_BITS-1] ? Y_MIN : Y_MAX;
        end
    end

    // delay line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else if (cmd.out_load) begin
            d2_reg <= d1_reg;
            d1_reg <= w_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= coef_mux * state_mux;
        end
        acc_reg <= acc_next;
        if (cmd.w_load) begin
            w_reg <= w_sat;
        end
        if (cmd.take_in) begin
            end_in_reg <= s_block_end;
        end
        if (cmd.out_load) begin
            y_reg       <= y_sat;
            end_out_reg <= end_in_reg;
        end
    end

    assign m_sample_out    = y_reg;
    assign m_block_end_out = end_out_reg;

endmodule

[hw/rtl/biquad_iir_filter_top.sv]
// ----------------------------------------------------------------------------
// biquad_iir_filter_top
// One direct-form-II biquad section on fixed-point audio samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel s_*: one request carries a Q1.23 sample and an
//    end-of-buffer flag; taken when s_valid and s_ready are both high.
//  - Output channel m_*: one request per input, the saturated Q1.23
//    result and a copy of the flag; taken when m_valid and m_ready are high.
//  - Config port: cfg_we writes cfg_wdata into coefficient cfg_addr
//    (0 ff0, 1 ff1, 2 ff2, 3 fb1, 4 fb2; other indexes are ignored).
//    Write only while no request is in flight.
//  - A taken request steps FB1, FB2, WSAT, FF0, FF1, FF2, then OUT sets m_valid.
//  - One sample at a time: the single shared 18x32 multiplier does five
//    products per sample in sequence before the next sample is taken.
//  - s_ready is high only in the idle state; the next sample is taken while
//    a finished result still waits in the output register.
//  - Receiver stall: the sequencer holds its last step until the output
//    register frees up; the state and the result are kept, nothing is lost.
//  - Reset (aresetn low, synchronous): s_ready is held low; coefficients go to
//    ff0 = 1.0, the rest 0; the delay line is cleared; no output request pending.
//  - block_end is only passed through; the delay line is never cleared by it.
// ----------------------------------------------------------------------------
module biquad_iir_filter_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_we,
    input  logic [biq_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [biq_pkg::COEF_BITS-1:0]        cfg_wdata,
    // input samples
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [biq_pkg::SAMPLE_BITS-1:0] s_sample_in,
    input  logic                                 s_block_end,
    // filtered samples
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [biq_pkg::SAMPLE_BITS-1:0] m_sample_out,
    output logic                                 m_block_end_out
);
    import biq_pkg::*;

    biq_cmd_t  cmd;    // sequencer -> datapath
    biq_coef_t coef;   // register file -> datapath

    // coefficient registers
    biq_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    // sequencer: feedback MACs, w saturation, feedforward MACs, output
    biq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // multiplier, accumulator, delay line, output register
    biq_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .coef            (coef),
        .s_sample_in     (s_sample_in),
        .s_block_end     (s_block_end),
        .m_sample_out    (m_sample_out),
        .m_block_end_out (m_block_end_out)
    );

endmodule

[hw/rtl/biq_checker.sv]
// ----------------------------------------------------------------------------
// biq_checker
// Port-level checks of the biquad section, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module biq_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [biq_pkg::SAMPLE_BITS-1:0] m_sample_out,
    input logic                                 m_block_end_out
);

    // stalled result stays offered
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // stalled result payload holds
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_sample_out) && $stable(m_block_end_out))

    // a taken sample keeps the block busy for its MAC sequence
    `ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready ##1 !s_ready)

    // a new result appears exactly as the sequencer returns to idle
    `ASSERT_SAME(a_result_at_idle, aclk, aresetn, $rose(m_valid), s_ready)

endmodule

bind biquad_iir_filter_top biq_checker u_biq_checker (.*);

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: biquad section regression
// Streams samples through one direct-form-II biquad under changing
// coefficient sets and checks every filtered sample and end-of-buffer flag
// against a fixed-point model kept in this bench.
// ----------------------------------------------------------------------------
module tb;

    import biq_pkg::*;

    localparam int SB          = SAMPLE_BITS;
    localparam int CB          = COEF_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PER_SET = 75;
    localparam int LAST_ADDR   = (1 << CFG_ADDR_BITS) - 1;

    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [CB-1:0] COEF_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] COEF_MIN = {1'b1, {(CB-1){1'b0}}};

    // one audio word: used for both the sample requests and the results
    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 buf_end;
    } audio_word_t;

    // kinds of coefficient sets visited by the random part, in run order
    typedef enum {
        SET_FIR,          // feedback off, random feedforward
        SET_DAMPED,       // small feedback, poles well inside the unit circle
        SET_WILD,         // anything goes, mostly unstable and clipping
        SET_ALL_MIN,      // every coefficient at -2.0
        SET_DAMPED_HOLD,  // damped, with a long receiver hold-off
        SET_DAMPED_CALM   // damped, no idling on either side
    } coef_plan_t;

    localparam int NUM_PLANS = 6;
    coef_plan_t plans [NUM_PLANS] = '{SET_FIR, SET_DAMPED, SET_WILD, SET_ALL_MIN,
                                      SET_DAMPED_HOLD, SET_DAMPED_CALM};

    // DUT ports; the driven inputs are all known from time zero
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CB-1:0]        cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [SB-1:0] s_sample_in = '0;
    logic                 s_block_end = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [SB-1:0] m_sample_out;
    logic                 m_block_end_out;

    // bench state
    audio_word_t samples_to_send [$];   // requests not yet offered
    audio_word_t filtered_due [$];      // predicted outputs, oldest first
    audio_word_t next_word;
    audio_word_t taken_word;
    audio_word_t got_word;
    audio_word_t want_word;
    biq_coef_t   coef_shadow = '{ff0: COEF_ONE, default: '0};
    longint      w_recent = 0;
    longint      w_older = 0;

    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_go = 1'b0;
    bit  calm = 1'b0;
    int  cycle_count = 0;
    int  mismatches = 0;
    int  samples_sent = 0;
    int  outputs_checked = 0;
    int  outputs_clipped = 0;
    int  sets_run = 0;

    biquad_iir_filter_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_in     (s_sample_in),
        .s_block_end     (s_block_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_out    (m_sample_out),
        .m_block_end_out (m_block_end_out)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point model of the section
    // ------------------------------------------------------------------

    // exact sum down to sample scale, round half up
    function automatic longint rescale(input longint acc);
        return (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // one sample through the section; advances the delay line
    function automatic audio_word_t filter_step(input audio_word_t in_word);
        longint      acc;
        longint      w;
        longint      y;
        audio_word_t out_word;
        acc = (longint'(in_word.sample) <<< COEF_FRAC)
            - longint'(coef_shadow.fb1) * w_recent
            - longint'(coef_shadow.fb2) * w_older;
        w = clamp(rescale(acc), W_BITS);
        acc = longint'(coef_shadow.ff0) * w
            + longint'(coef_shadow.ff1) * w_recent
            + longint'(coef_shadow.ff2) * w_older;
        y = clamp(rescale(acc), SB);
        w_older  = w_recent;
        w_recent = w;
        out_word.sample  = y[SB-1:0];
        out_word.buf_end = in_word.buf_end;
        return out_word;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers queued requests, idles in random bursts
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            // prediction is made at acceptance, with the coefficients in force
            if (s_valid && s_ready) begin
                taken_word.sample  = s_sample_in;
                taken_word.buf_end = s_block_end;
                filtered_due = {filtered_due, filter_step(taken_word)};
                samples_sent++;
            end
            // a request still waiting keeps valid and payload as they are
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (samples_to_send.size() != 0 &&
                             (calm || $urandom_range(0, 5) != 0)) begin
                    next_word = samples_to_send.pop_front();
                    s_valid     <= 1'b1;
                    s_sample_in <= next_word.sample;
                    s_block_end <= next_word.buf_end;
                end else begin
                    s_valid <= 1'b0;
                    // start an idle burst, this cycle included; send_gap gets a random length
                    if (samples_to_send.size() != 0)
                        send_gap <= $urandom_range(0, 7);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here so the sender keeps going
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got_word = '{sample: m_sample_out, buf_end: m_block_end_out};
                if (got_word.sample == SAMPLE_MAX || got_word.sample == SAMPLE_MIN)
                    outputs_clipped++;
                if (filtered_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] output with nothing expected: sample %h end %b",
                                 $realtime, got_word.sample, got_word.buf_end);
                end else begin
                    want_word = filtered_due.pop_front();
                    if (got_word.sample !== want_word.sample ||
                        got_word.buf_end !== want_word.buf_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] out %0d: exp %h got %h, end exp %b got %b",
                                     $realtime, outputs_checked,
                                     want_word.sample, got_word.sample,
                                     want_word.buf_end, got_word.buf_end);
                    end
                    outputs_checked++;
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                m_ready  <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready  <= 1'b0;
                recv_gap <= $urandom_range(0, 7);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d outputs still due",
                 cycle_count, filtered_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_sample(input logic signed [SB-1:0] value,
                                         input logic flag);
        audio_word_t word;
        word.sample  = value;
        word.buf_end = flag;
        samples_to_send = {samples_to_send, word};
    endfunction

    // mostly full-range noise, with extremes and near-zero values mixed in
    function automatic logic signed [SB-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SB'($urandom_range(0, 510) - 255);
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [CB-1:0] random_coef();
        return CB'($urandom);
    endfunction

    // settles at the falling edge so queues and valid are stable
    task automatic wait_idle();
        do @(negedge aclk);
        while (samples_to_send.size() != 0 || s_valid || filtered_due.size() != 0);
    endtask

    // one register write; the shadow copy follows the same decode
    task automatic write_coef(input logic [CFG_ADDR_BITS-1:0] addr,
                              input logic [CB-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            REG_FF0: coef_shadow.ff0 = value;
            REG_FF1: coef_shadow.ff1 = value;
            REG_FF2: coef_shadow.ff2 = value;
            REG_FB1: coef_shadow.fb1 = value;
            REG_FB2: coef_shadow.fb2 = value;
            default: ;  // unmapped index, block ignores it
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_coefs(input logic [CB-1:0] ff0, input logic [CB-1:0] ff1,
                             input logic [CB-1:0] ff2, input logic [CB-1:0] fb1,
                             input logic [CB-1:0] fb2);
        write_coef(REG_FF0, ff0);
        write_coef(REG_FF1, ff1);
        write_coef(REG_FF2, ff2);
        write_coef(REG_FB1, fb1);
        write_coef(REG_FB2, fb2);
        sets_run++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset coefficients are a unity passthrough: extremes and bit
        // patterns should come back unchanged, flag in both states.
        @(negedge aclk);
        queue_sample('0, 1'b0);
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample(SB'(1), 1'b1);
        queue_sample(SB'(-1), 1'b0);
        queue_sample(SB'(24'h555555), 1'b1);
        queue_sample(SB'(24'hAAAAAA), 1'b0);
        queue_sample('0, 1'b1);
        wait_idle();

        // Writes to unmapped indexes must leave every coefficient alone.
        for (int addr = REG_FB2 + 1; addr <= LAST_ADDR; addr++)
            write_coef(CFG_ADDR_BITS'(addr), random_coef());

        // Extreme coefficients with full-scale input: the state runs into
        // its 32-bit clamp and the output into its sample clamp.
        set_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN);
        @(negedge aclk);
        for (int i = 0; i < 6; i++) queue_sample(SAMPLE_MAX, 1'(i == 5));
        for (int i = 0; i < 6; i++) queue_sample(SAMPLE_MIN, 1'(i == 5));
        wait_idle();

        // Random part: one batch per coefficient set, delay line carried over.
        foreach (plans[p]) begin
            case (plans[p])
                SET_FIR:
                    set_coefs(random_coef(), random_coef(), random_coef(), '0, '0);
                SET_WILD:
                    set_coefs(random_coef(), random_coef(), random_coef(),
                              random_coef(), random_coef());
                SET_ALL_MIN:
                    set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
                default:
                    // |fb1| <= 0.5, |fb2| <= 0.25 keeps the poles inside
                    set_coefs(random_coef(), random_coef(), random_coef(),
                              CB'($urandom_range(0, 65536) - 32768),
                              CB'($urandom_range(0, 32768) - 16384));
            endcase
            @(negedge aclk);
            if (plans[p] == SET_DAMPED_CALM) calm = 1'b1;
            if (plans[p] == SET_DAMPED_HOLD) begin
                // receiver blocks while the sender keeps offering
                hold_go <= 1'b1;
                @(negedge aclk);
                hold_go <= 1'b0;
            end
            for (int i = 0; i < RANDOM_PER_SET; i++)
                queue_sample(random_sample(), 1'($urandom_range(0, 7) == 0));
            wait_idle();
        end

        // latency tail: anything arriving now is unexpected
        repeat (16) @(posedge aclk);

        $display("%0d samples sent, %0d outputs checked under %0d coefficient sets",
                 samples_sent, outputs_checked, sets_run + 1);
        $display("%0d outputs clipped at full scale, %0d mismatches",
                 outputs_clipped, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
